[hw/rtl/cdst_pkg.sv]
package cdst_pkg;

   // fixed field widths
   localparam int SECS_W      = 16;
   localparam int SECS_IDX_W  = 4;
   localparam int SCALE_W     = 24;
   localparam int LIGHT_W     = 10;
   localparam int MINCAL_W    = 16;
   localparam int TIME_W      = 17;
   localparam int TICKS_OUT_W = 32;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 80;
   localparam int PROD_W      = SECS_W + SCALE_W;

   // clock conversion
   localparam logic [TIME_W-1:0] HOUR_SECS   = 17'd3600;
   localparam logic [TIME_W-1:0] MINUTE_SECS = 17'd60;
   localparam logic [TIME_W:0]   DAY_SECS    = 18'd86400;

   localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

   // register reset values
   localparam logic [LIGHT_W-1:0]  LIGHT_THR_RST  = 10'd20;
   localparam logic [MINCAL_W-1:0] MIN_CAL_RST    = 16'd300;
   localparam logic [SCALE_W-1:0]  INIT_SCALE_RST = 24'd65536;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_LIGHT_THR  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_CAL    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_INIT_SCALE = 2'd2;

   localparam logic OP_ENTER = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef enum logic [2:0] {
      ACT_START       = 3'd0,
      ACT_POWER_DOWN  = 3'd1,
      ACT_WAKE        = 3'd2,
      ACT_LIGHT_SLEEP = 3'd3,
      ACT_SAVE        = 3'd4
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_STOP,
      ST_DIV,
      ST_BLEND,
      ST_MUL_INIT,
      ST_MUL,
      ST_LOAD,
      ST_FINISH
   } state_type;

endpackage

[hw/rtl/calibrated_deep_sleep_timer_top.sv]
// Deep-sleep countdown in watchdog ticks, self-calibrating against the RTC.
// An enter beat (tuser 0) loads the countdown with sleep_seconds times the
// Q8.16 ticks-per-second scale, saturated to the count width. Each tick beat
// (tuser 1) counts down, arms a wake on a button press, ends the sleep early
// when light exceeds the threshold and restarts or finishes the sleep at zero.
// Every stop that saw at least min_calibration_ticks measures ticks/seconds
// (midnight wrap handled, zero elapsed skipped) and blends it in as
// (old + 3*new)/4. One beat is worked at a time; req_tready is high only
// when idle, while the result register lets a finished beat wait for
// rsp_tready without holding up the next request. A single shared adder
// serves the divide, one quotient bit per cycle, and the multiply, one bit
// of sleep_seconds per cycle. Writing initial_scale also reloads the live
// scale. No clearing pass after reset.
module calibrated_deep_sleep_timer_top
   import cdst_pkg::*;
#(
   parameter int SCALE_FRAC_BITS = 16,
   parameter int COUNT_WIDTH     = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // button_pressed, light_level, clock_hour, clock_minute, clock_second,
   // sleep_seconds
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic                  req_tuser,
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // point_on, scale_out, ticks_left, recalibrated, measured_seconds
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // action
   output logic [2:0]            rsp_tuser,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DIV_W  = COUNT_WIDTH + SCALE_FRAC_BITS;
   localparam int CNT_W  = $clog2(DIV_W);
   localparam int TCMP_W = (COUNT_WIDTH > MINCAL_W) ? COUNT_WIDTH : MINCAL_W;
   localparam logic [PROD_W-1:0] COUNT_MAX_P = PROD_W'({COUNT_WIDTH{1'b1}});
   localparam int RSP_PAD_W = RSP_DATA_W - (1 + SCALE_W + TICKS_OUT_W + 1 + TIME_W);

   // control
   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic restart_ff, restart_in;

   // config
   logic [LIGHT_W-1:0]  light_thr_ff, light_thr_in;
   logic [MINCAL_W-1:0] min_cal_ff, min_cal_in;

   // architectural state
   logic [COUNT_WIDTH-1:0] countdown_ff, countdown_in;
   logic [COUNT_WIDTH-1:0] start_ticks_ff, start_ticks_in;
   logic [TIME_W-1:0]      start_time_ff, start_time_in;
   logic [SCALE_W-1:0]     tick_scale_ff, tick_scale_in;
   logic                   wake_ff, wake_in;

   // latched request
   logic                   op_ff, op_in;
   logic                   btn_ff, btn_in;
   logic [LIGHT_W-1:0]     light_ff, light_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [SECS_W-1:0]      secs_ff, secs_in;

   // per-beat result
   action_type             act_ff, act_in;
   logic                   point_ff, point_in;
   logic                   recal_ff, recal_in;
   logic [TIME_W-1:0]      meas_ff, meas_in;

   // shared datapath
   logic [PROD_W-1:0]      acc_ff, acc_in;
   logic [DIV_W-1:0]       dvd_ff, dvd_in;
   logic [TIME_W-1:0]      rem_ff, rem_in;
   logic [TIME_W-1:0]      elapsed_ff, elapsed_in;
   logic [SCALE_W-1:0]     quo_ff, quo_in;
   logic                   ovf_ff, ovf_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [2:0]             rsp_user_ff, rsp_user_in;

   // shared adder
   logic [PROD_W-1:0]      alu_a, alu_b;
   logic                   alu_cin;
   logic [PROD_W:0]        alu_sum;

   assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {{PROD_W{1'b0}}, alu_cin};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         light_thr_ff   <= LIGHT_THR_RST;
         min_cal_ff     <= MIN_CAL_RST;
         countdown_ff   <= '0;
         start_ticks_ff <= '0;
         start_time_ff  <= '0;
         tick_scale_ff  <= INIT_SCALE_RST;
         wake_ff        <= 1'b0;
         restart_ff     <= 1'b0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         light_thr_ff   <= light_thr_in;
         min_cal_ff     <= min_cal_in;
         countdown_ff   <= countdown_in;
         start_ticks_ff <= start_ticks_in;
         start_time_ff  <= start_time_in;
         tick_scale_ff  <= tick_scale_in;
         wake_ff        <= wake_in;
         restart_ff     <= restart_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      btn_ff      <= btn_in;
      light_ff    <= light_in;
      now_ff      <= now_in;
      secs_ff     <= secs_in;
      act_ff      <= act_in;
      point_ff    <= point_in;
      recal_ff    <= recal_in;
      meas_ff     <= meas_in;
      acc_ff      <= acc_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      elapsed_ff  <= elapsed_in;
      quo_ff      <= quo_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      logic [COUNT_WIDTH-1:0] ticks;
      logic [TIME_W:0]        el_wide;
      logic [TIME_W:0]        rem_sh;
      logic                   ge;
      logic [PROD_W-1:0]      prod_shr;
      logic [SCALE_W-1:0]     fresh;
      logic [SCALE_W+1:0]     blend;
      state_type              after_stop;

      state_in       = state_ff;
      cnt_in         = cnt_ff;
      restart_in     = restart_ff;
      light_thr_in   = light_thr_ff;
      min_cal_in     = min_cal_ff;
      countdown_in   = countdown_ff;
      start_ticks_in = start_ticks_ff;
      start_time_in  = start_time_ff;
      tick_scale_in  = tick_scale_ff;
      wake_in        = wake_ff;
      op_in          = op_ff;
      btn_in         = btn_ff;
      light_in       = light_ff;
      now_in         = now_ff;
      secs_in        = secs_ff;
      act_in         = act_ff;
      point_in       = point_ff;
      recal_in       = recal_ff;
      meas_in        = meas_ff;
      acc_in         = acc_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      elapsed_in     = elapsed_ff;
      quo_in         = quo_ff;
      ovf_in         = ovf_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      alu_a          = '0;
      alu_b          = '0;
      alu_cin        = 1'b0;

      ticks      = start_ticks_ff - countdown_ff;
      el_wide    = (now_ff < start_time_ff) ?
                   ({1'b0, now_ff} + DAY_SECS - {1'b0, start_time_ff}) :
                   ({1'b0, now_ff} - {1'b0, start_time_ff});
      rem_sh     = {rem_ff, dvd_ff[DIV_W-1]};
      ge         = 1'b0;
      prod_shr   = acc_ff >> SCALE_FRAC_BITS;
      fresh      = ovf_ff ? SCALE_MAX : quo_ff;
      blend      = {2'b00, tick_scale_ff} + {2'b00, fresh} + {1'b0, fresh, 1'b0};
      after_stop = restart_ff ? ST_MUL_INIT : ST_FINISH;

      // result register drains independently of the sequencer
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               btn_in   = req_tdata[0];
               light_in = req_tdata[10:1];
               now_in   = TIME_W'(req_tdata[15:11]) * HOUR_SECS
                        + TIME_W'(req_tdata[21:16]) * MINUTE_SECS
                        + TIME_W'(req_tdata[27:22]);
               secs_in  = req_tdata[43:28];
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            point_in   = 1'b0;
            recal_in   = 1'b0;
            meas_in    = '0;
            restart_in = 1'b0;
            if (op_ff == OP_ENTER) begin
               wake_in  = 1'b0;
               act_in   = ACT_START;
               state_in = ST_MUL_INIT;
            end else begin
               if (btn_ff) begin
                  wake_in  = 1'b1;
                  point_in = 1'b1;
               end
               if (!btn_ff && wake_ff) begin
                  act_in   = ACT_WAKE;
                  state_in = ST_STOP;
               end else if (countdown_ff != '0) begin
                  countdown_in = countdown_ff - COUNT_WIDTH'(1);
                  if (light_ff > light_thr_ff) begin
                     act_in   = ACT_LIGHT_SLEEP;
                     state_in = ST_STOP;
                  end else begin
                     act_in   = ACT_POWER_DOWN;
                     state_in = ST_FINISH;
                  end
               end else if (secs_ff == '0) begin
                  act_in   = ACT_SAVE;
                  state_in = ST_FINISH;
               end else begin
                  // period over: measure, then start a fresh countdown
                  act_in     = ACT_POWER_DOWN;
                  restart_in = 1'b1;
                  state_in   = ST_STOP;
               end
            end
         end
         ST_STOP: begin
            if (TCMP_W'(ticks) < TCMP_W'(min_cal_ff)) begin
               state_in = after_stop;
            end else begin
               meas_in    = el_wide[TIME_W-1:0];
               elapsed_in = el_wide[TIME_W-1:0];
               if (el_wide[TIME_W-1:0] == '0) begin
                  state_in = after_stop;
               end else begin
                  dvd_in   = DIV_W'(ticks) << SCALE_FRAC_BITS;
                  rem_in   = '0;
                  quo_in   = '0;
                  ovf_in   = 1'b0;
                  cnt_in   = CNT_W'(DIV_W - 1);
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            alu_a   = PROD_W'(rem_sh);
            alu_b   = ~PROD_W'(elapsed_ff);
            alu_cin = 1'b1;
            ge      = alu_sum[PROD_W];
            rem_in  = ge ? alu_sum[TIME_W-1:0] : rem_sh[TIME_W-1:0];
            quo_in  = {quo_ff[SCALE_W-2:0], ge};
            ovf_in  = ovf_ff | quo_ff[SCALE_W-1];
            dvd_in  = dvd_ff << 1;
            if (cnt_ff == '0) begin
               state_in = ST_BLEND;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_BLEND: begin
            tick_scale_in = blend[SCALE_W+1:2];
            recal_in      = 1'b1;
            state_in      = after_stop;
         end
         ST_MUL_INIT: begin
            acc_in   = '0;
            cnt_in   = CNT_W'(SECS_W - 1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // shift-add, sleep_seconds MSB first
            alu_a  = acc_ff << 1;
            alu_b  = secs_ff[cnt_ff[SECS_IDX_W-1:0]] ? PROD_W'(tick_scale_ff) : '0;
            acc_in = alu_sum[PROD_W-1:0];
            if (cnt_ff == '0) begin
               state_in = ST_LOAD;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_LOAD: begin
            start_ticks_in = (prod_shr > COUNT_MAX_P) ? '1 : prod_shr[COUNT_WIDTH-1:0];
            countdown_in   = (prod_shr > COUNT_MAX_P) ? '1 : prod_shr[COUNT_WIDTH-1:0];
            start_time_in  = now_ff;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = act_ff;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, meas_ff, recal_ff,
                               TICKS_OUT_W'(countdown_ff), tick_scale_ff, point_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes are to arrive only while idle; the block does not enforce it
      if (csr_we) begin
         case (csr_addr)
            CSR_LIGHT_THR:  light_thr_in  = csr_wdata[LIGHT_W-1:0];
            CSR_MIN_CAL:    min_cal_in    = csr_wdata[MINCAL_W-1:0];
            CSR_INIT_SCALE: tick_scale_in = csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

`ifndef ASSERT_OFF
   // one beat in flight at a time
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < elapsed_ff))
      else $error("divider remainder out of range");

   // a recalibration always comes with a non-zero measurement
   a_recal_meas: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[57]) |-> (rsp_data_ff[74:58] != '0))
      else $error("recalibrated without elapsed time");

   // an enter never measures nor lights the point
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff == ACT_START) |->
      (!rsp_data_ff[0] && !rsp_data_ff[57] && rsp_data_ff[74:58] == '0))
      else $error("start result carries tick fields");
`endif

endmodule

[tb/sv/calibrated_deep_sleep_timer_top_tb.sv]
`timescale 1ns / 100ps

module calibrated_deep_sleep_timer_top_tb;
   import cdst_pkg::*;

   localparam int FRAC_BITS   = 16;
   localparam int SPAN_W      = TIME_W + 2;
   localparam int MIX_W       = SCALE_W + 3;
   localparam int TOTAL_BEATS = 1550;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int SETTLE      = 100;

   // request beat, first field in the lowest bits (packed struct lists MSB first)
   typedef struct packed {
      logic [SECS_W-1:0]  sleep_seconds;
      logic [5:0]         sec;
      logic [5:0]         minute;
      logic [4:0]         hour;
      logic [LIGHT_W-1:0] light;
      logic               button;
   } sleep_req_t;

   typedef struct packed {
      logic [TIME_W-1:0]      measured;
      logic                   recal;
      logic [TICKS_OUT_W-1:0] ticks_left;
      logic [SCALE_W-1:0]     scale;
      logic                   point_on;
   } sleep_rsp_t;

   typedef struct packed {
      action_type action;
      sleep_rsp_t data;
   } sleep_result_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   calibrated_deep_sleep_timer_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the timer: registers and sleep state as the block should hold them
   logic [LIGHT_W-1:0]     cfg_light_thr;
   logic [MINCAL_W-1:0]    cfg_floor_ticks;
   logic [SCALE_W-1:0]     cfg_init_scale;
   logic [TICKS_OUT_W-1:0] sleep_count;
   logic [TICKS_OUT_W-1:0] sleep_start_ticks;
   logic [TIME_W-1:0]      sleep_start_secs;
   logic [SCALE_W-1:0]     ticks_scale;
   logic                   wake_armed;

   sleep_result_t pending_outcomes[$];
   int            beats_sent      = 0;
   int            results_seen    = 0;
   int            error_count     = 0;
   int            rsp_hold_cycles = 0;
   bit            idle_en         = 1'b0;
   int            cycle_count     = 0;
   sleep_rsp_t    seen_rsp;
   sleep_result_t want_rsp;

   // Mostly back-to-back, now and then a long pause
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_en || r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic sleep_req_t make_req(input logic button, input int light, input int t,
                                           input int secs);
      sleep_req_t rq;
      rq.button        = button;
      rq.light         = LIGHT_W'(light);
      rq.hour          = 5'(t / 3600);
      rq.minute        = 6'((t % 3600) / 60);
      rq.sec           = 6'(t % 60);
      rq.sleep_seconds = SECS_W'(secs);
      return rq;
   endfunction

   // seconds times scale, Q8.16 -> whole ticks (never exceeds the count width)
   function automatic void load_countdown(input logic [TIME_W-1:0] now,
                                          input logic [SECS_W-1:0] secs);
      logic [PROD_W-1:0] prod;
      prod              = PROD_W'(secs) * PROD_W'(ticks_scale);
      sleep_start_ticks = TICKS_OUT_W'(prod >> FRAC_BITS);
      sleep_count       = sleep_start_ticks;
      sleep_start_secs  = now;
   endfunction

   // End of a sleep: measure ticks against RTC seconds and blend in 1:3
   function automatic void measure_sleep(input logic [TIME_W-1:0] now, output logic recal,
                                         output logic seen, output logic [TIME_W-1:0] secs);
      logic [TICKS_OUT_W-1:0] ticks;
      logic [SPAN_W-1:0]      span;
      logic [47:0]            fresh;
      logic [MIX_W-1:0]       mix;
      recal = 1'b0;
      seen  = 1'b0;
      secs  = '0;
      ticks = sleep_start_ticks - sleep_count;
      if (ticks >= TICKS_OUT_W'(cfg_floor_ticks)) begin
         // midnight wrap
         if (now < sleep_start_secs)
            span = SPAN_W'(now) + SPAN_W'(DAY_SECS) - SPAN_W'(sleep_start_secs);
         else
            span = SPAN_W'(now) - SPAN_W'(sleep_start_secs);
         secs = span[TIME_W-1:0];
         seen = 1'b1;
         if (secs != '0) begin
            fresh = {ticks, {FRAC_BITS{1'b0}}} / 48'(secs);
            if (fresh > 48'(SCALE_MAX))
               fresh = 48'(SCALE_MAX);
            mix         = MIX_W'(ticks_scale) + MIX_W'(3) * MIX_W'(fresh[SCALE_W-1:0]);
            ticks_scale = mix[SCALE_W+1:2];
            recal       = 1'b1;
         end
      end
   endfunction

   function automatic sleep_result_t predict_timer_step(input logic op, input sleep_req_t rq);
      sleep_result_t     res;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] meas;
      logic              recal;
      logic              seen;
      logic              done;
      res    = '0;
      recal  = 1'b0;
      seen   = 1'b0;
      meas   = '0;
      done   = 1'b0;
      now    = TIME_W'(rq.hour) * HOUR_SECS + TIME_W'(rq.minute) * MINUTE_SECS
               + TIME_W'(rq.sec);
      res.action = ACT_POWER_DOWN;
      if (op == OP_ENTER) begin
         load_countdown(now, rq.sleep_seconds);
         wake_armed = 1'b0;
         res.action = ACT_START;
      end else begin
         if (rq.button) begin
            wake_armed        = 1'b1;
            res.data.point_on = 1'b1;
         end else if (wake_armed) begin
            // armed wake: stop, count left alone
            res.action = ACT_WAKE;
            measure_sleep(now, recal, seen, meas);
            done = 1'b1;
         end
         if (!done) begin
            if (sleep_count != '0) begin
               sleep_count = sleep_count - 1'b1;
               if (rq.light > cfg_light_thr) begin
                  res.action = ACT_LIGHT_SLEEP;
                  measure_sleep(now, recal, seen, meas);
               end
            end else if (rq.sleep_seconds == '0) begin
               res.action = ACT_SAVE;
            end else begin
               // period over but more sleep wanted: measure, then restart
               measure_sleep(now, recal, seen, meas);
               load_countdown(now, rq.sleep_seconds);
            end
         end
      end
      res.data.scale      = ticks_scale;
      res.data.ticks_left = sleep_count;
      res.data.recal      = recal;
      res.data.measured   = seen ? meas : '0;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < 50)
         $display("%0t: %s wrong on result %0d: got 0x%0h, expected 0x%0h",
                  $time, what, results_seen, got, want);
      error_count++;
   endtask

   // Called at a falling edge; returns at a falling edge, tvalid left high when no gap follows
   task automatic send_beat(input logic op, input sleep_req_t rq);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'(rq);
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      pending_outcomes.push_back(predict_timer_step(op, rq));
      beats_sent++;
      @(negedge clock);
      gap = idle_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Sender stops and waits for every outstanding result; block is idle afterwards
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   // All three registers in a row, enable held high throughout
   task automatic set_config(input logic [LIGHT_W-1:0] thr,
                             input logic [MINCAL_W-1:0] floor_ticks,
                             input logic [SCALE_W-1:0] scale);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_LIGHT_THR;
      csr_wdata <= CSR_DATA_W'(thr);
      @(negedge clock);
      csr_addr  <= CSR_MIN_CAL;
      csr_wdata <= CSR_DATA_W'(floor_ticks);
      @(negedge clock);
      csr_addr  <= CSR_INIT_SCALE;
      csr_wdata <= CSR_DATA_W'(scale);
      @(negedge clock);
      csr_we          <= 1'b0;
      cfg_light_thr   = thr;
      cfg_floor_ticks = floor_ticks;
      cfg_init_scale  = scale;
      ticks_scale     = scale;    // writing the initial scale reloads the live one
   endtask

   // One sleep: enter, then a run of ticks with a drifting RTC
   task automatic sleep_session();
      sleep_req_t rq;
      int         t;
      int         secs;
      int         n_ticks;
      t = $urandom_range(0, 86399);
      case ($urandom_range(0, 9))
         0:       secs = 65535;
         1:       secs = 0;
         2, 3:    secs = $urandom_range(0, 65535);
         default: secs = $urandom_range(0, 20);
      endcase
      send_beat(OP_ENTER, make_req(1'b0, $urandom_range(0, 1023), t, secs));
      n_ticks = $urandom_range(1, 20);
      repeat (n_ticks) begin
         if ($urandom_range(0, 19) == 0)
            t = $urandom_range(0, 86399);
         else
            t = (t + $urandom_range(0, 30)) % 86400;
         case ($urandom_range(0, 9))
            0, 1:    secs = 0;
            2:       secs = $urandom_range(0, 65535);
            default: secs = $urandom_range(1, 20);
         endcase
         rq       = make_req($urandom_range(0, 9) == 0, 0, t, secs);
         rq.light = ($urandom_range(0, 4) == 0) ? LIGHT_W'($urandom_range(0, 1023))
                                                : LIGHT_W'($urandom_range(0, cfg_light_thr));
         send_beat(OP_TICK, rq);
      end
   endtask

   // Raw beats, every bit random, clock fields out of range included
   task automatic noise_beats();
      logic [63:0] raw;
      repeat ($urandom_range(1, 6)) begin
         raw = {$urandom, $urandom};
         send_beat(1'($urandom_range(0, 1)), raw[$bits(sleep_req_t)-1:0]);
      end
   endtask

   task automatic test_directed();
      sleep_req_t rq;
      idle_en = 1'b0;
      // reset values, floor 300: nothing short gets measured
      send_beat(OP_ENTER, make_req(1'b0, 0, 0, 0));
      send_beat(OP_TICK, make_req(1'b0, 0, 1, 0));       // count zero, no more sleep: save
      send_beat(OP_TICK, make_req(1'b0, 0, 2, 5));       // count zero: restart with 5 ticks
      send_beat(OP_TICK, make_req(1'b0, 21, 3, 5));      // just above threshold
      send_beat(OP_TICK, make_req(1'b0, 20, 4, 5));      // at threshold: keeps sleeping
      send_beat(OP_TICK, make_req(1'b1, 0, 5, 5));       // press arms wake, still counts
      send_beat(OP_TICK, make_req(1'b1, 1023, 6, 5));
      send_beat(OP_TICK, make_req(1'b0, 0, 7, 5));       // release: wake
      send_beat(OP_TICK, make_req(1'b0, 1023, 8, 5));    // wake stays armed
      send_beat(OP_ENTER, make_req(1'b0, 0, 100, 3));    // enter clears it
      wait_drain();
      set_config(LIGHT_THR_RST, '0, INIT_SCALE_RST);
      send_beat(OP_ENTER, make_req(1'b0, 0, 86390, 65535));
      send_beat(OP_TICK, make_req(1'b0, 1023, 10, 65535));   // measured across midnight
      rq      = make_req(1'b0, 0, 0, 10);
      rq.hour = '1;
      rq.minute = '1;
      rq.sec  = '1;
      send_beat(OP_ENTER, rq);
      rq.light = 1023;
      send_beat(OP_TICK, rq);                              // zero elapsed: no update
      wait_drain();
      set_config('1, '0, SCALE_MAX);
      send_beat(OP_ENTER, make_req(1'b0, 0, 1000, 65535)); // largest product
      send_beat(OP_TICK, make_req(1'b0, 1023, 1001, 1)); // threshold at top: never exceeded
      send_beat(OP_TICK, make_req(1'b1, 0, 1005, 1));
      send_beat(OP_TICK, make_req(1'b0, 0, 1010, 1));
      wait_drain();
      // smallest scale: zero ticks measured drives it to zero, and it stays there
      set_config('0, '0, 24'd1);
      send_beat(OP_ENTER, make_req(1'b0, 0, 500, 0));
      send_beat(OP_TICK, make_req(1'b0, 0, 600, 7));
      send_beat(OP_ENTER, make_req(1'b0, 0, 700, 65535));
      send_beat(OP_TICK, make_req(1'b0, 1, 701, 0));
   endtask

   // Calibration floor at its reset value: 300 ticks measure, 299 do not
   task automatic test_calibration_floor();
      wait_drain();
      idle_en = 1'b1;
      set_config(LIGHT_THR_RST, MIN_CAL_RST, INIT_SCALE_RST);
      send_beat(OP_ENTER, make_req(1'b0, 0, 43200, 400));
      repeat (299) send_beat(OP_TICK, make_req(1'b0, 0, 43200, 400));
      send_beat(OP_TICK, make_req(1'b0, 1023, 43201, 400));   // 300 ticks in 1 s: clamps
      wait_drain();
      set_config(LIGHT_THR_RST, MIN_CAL_RST, INIT_SCALE_RST);
      send_beat(OP_ENTER, make_req(1'b0, 0, 43200, 400));
      repeat (298) send_beat(OP_TICK, make_req(1'b0, 0, 43200, 400));
      send_beat(OP_TICK, make_req(1'b0, 1023, 43201, 400));
   endtask

   task automatic test_backpressure();
      wait_drain();
      set_config(LIGHT_THR_RST, 16'd2, INIT_SCALE_RST);
      // receiver holds off while beats keep coming: the block must stall its input
      idle_en         = 1'b0;
      rsp_hold_cycles = 400;
      repeat (4) sleep_session();
      // sender pauses until every result is back
      wait_drain();
      idle_en = 1'b1;
      repeat (4) sleep_session();
   endtask

   task automatic test_random_sleeps();
      int                  phase;
      logic [LIGHT_W-1:0]  thr;
      logic [MINCAL_W-1:0] floor_ticks;
      logic [SCALE_W-1:0]  scale;
      phase = 0;
      while (beats_sent < TOTAL_BEATS) begin
         wait_drain();
         case ($urandom_range(0, 4))
            0:       thr = '0;
            1:       thr = '1;
            2:       thr = LIGHT_THR_RST;
            default: thr = LIGHT_W'($urandom_range(0, 1023));
         endcase
         case ($urandom_range(0, 5))
            0:       floor_ticks = '1;
            1:       floor_ticks = MIN_CAL_RST;
            2, 3:    floor_ticks = '0;
            default: floor_ticks = MINCAL_W'($urandom_range(0, 6));
         endcase
         case ($urandom_range(0, 4))
            0:       scale = SCALE_MAX;
            1:       scale = 24'd1;
            2:       scale = SCALE_W'($urandom_range(1, 24'hFFFFFF));
            default: scale = SCALE_W'($urandom_range(16384, 262144));
         endcase
         // first two phases pinned to the extremes
         if (phase == 0) begin
            thr         = '0;
            floor_ticks = '0;
            scale       = SCALE_MAX;
         end else if (phase == 1) begin
            thr         = '1;
            floor_ticks = '1;
            scale       = 24'd1;
         end
         set_config(thr, floor_ticks, scale);
         idle_en = (phase % 4 != 3);    // every fourth phase runs flat out
         repeat (8) begin
            if ($urandom_range(0, 9) == 0)
               noise_beats();
            else
               sleep_session();
         end
         phase++;
      end
   endtask

   // Result side: random tready, or a long hold-off when a test asks for one
   initial begin
      int   n;
      logic rdy;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles != 0) begin
            n               = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rdy             = 1'b0;
         end else begin
            n   = idle_gap();
            rdy = (n == 0);
            if (rdy)
               n = $urandom_range(1, 6);
         end
         rsp_tready <= rdy;
         repeat (n) @(negedge clock);
      end
   end

   // Every accepted result against the oldest outstanding prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         seen_rsp = rsp_tdata[$bits(sleep_rsp_t)-1:0];
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected beat", 32'(rsp_tuser), 32'(0));
         end else begin
            want_rsp = pending_outcomes.pop_front();
            if (rsp_tuser !== want_rsp.action)
               report_mismatch("action", 32'(rsp_tuser), 32'(want_rsp.action));
            if (seen_rsp.point_on !== want_rsp.data.point_on)
               report_mismatch("point_on", 32'(seen_rsp.point_on), 32'(want_rsp.data.point_on));
            if (seen_rsp.scale !== want_rsp.data.scale)
               report_mismatch("scale_out", 32'(seen_rsp.scale), 32'(want_rsp.data.scale));
            if (seen_rsp.ticks_left !== want_rsp.data.ticks_left)
               report_mismatch("ticks_left", seen_rsp.ticks_left, want_rsp.data.ticks_left);
            if (seen_rsp.recal !== want_rsp.data.recal)
               report_mismatch("recalibrated", 32'(seen_rsp.recal), 32'(want_rsp.data.recal));
            if (seen_rsp.measured !== want_rsp.data.measured)
               report_mismatch("measured_seconds", 32'(seen_rsp.measured),
                               32'(want_rsp.data.measured));
         end
         results_seen++;
      end
   end

   // Watchdog on the whole run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = OP_ENTER;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = CSR_LIGHT_THR;
      csr_wdata  = '0;
      // shadow registers and state as after reset
      cfg_light_thr     = LIGHT_THR_RST;
      cfg_floor_ticks   = MIN_CAL_RST;
      cfg_init_scale    = INIT_SCALE_RST;
      ticks_scale       = INIT_SCALE_RST;
      sleep_count       = '0;
      sleep_start_ticks = '0;
      sleep_start_secs  = '0;
      wake_armed        = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_calibration_floor();
      test_backpressure();
      test_random_sleeps();
      wait_drain();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
